// File: rtl/dssl_pkg.sv
// Shared types and constants of the drive speed safety limiter.
package dssl_pkg;

    // Speed and limit scaling
    localparam int unsigned ONE_Q14 = 16384;
    localparam int unsigned LIM_W = 15;
    localparam int unsigned QUOT_W = 14;
    localparam int unsigned DIV_STEPS = 14;
    localparam int unsigned DRIVE_SCALE = 200;

    // Tick counter is kept as thousands and units of a thousand
    localparam int unsigned BLINK_PERIOD = 1000;
    localparam int unsigned KILO_WRAP = 30;
    localparam logic [7:0] BLINK_PATTERN = 8'd86;

    // Configuration register indexes
    localparam logic [2:0] CFG_STOP_DIST = 3'd0;
    localparam logic [2:0] CFG_BRAKE_DIST = 3'd1;
    localparam logic [2:0] CFG_BATT_LIMIT = 3'd2;
    localparam logic [2:0] CFG_BATT_GUARD = 3'd3;
    localparam logic [2:0] CFG_FRONT_GUARD = 3'd4;
    localparam logic [2:0] CFG_REAR_GUARD = 3'd5;

    // Status codes
    localparam logic [1:0] BATT_OK = 2'd0;
    localparam logic [1:0] BATT_POWER = 2'd1;
    localparam logic [1:0] BATT_COMPUTE = 2'd2;
    localparam logic [1:0] GUARD_FREE = 2'd0;
    localparam logic [1:0] GUARD_BRAKE = 2'd1;
    localparam logic [1:0] GUARD_STOP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRONT_START,
        ST_FRONT_DIV,
        ST_REAR_START,
        ST_REAR_DIV,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel_rear;
        logic cap_front;
        logic cap_rear;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [LIM_W-1:0] lim;
    } guard_t;

endpackage

// File: rtl/dssl_div.sv
// Restoring divider, one quotient bit per cycle, for the braking ratio.
module dssl_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [15:0]                     num,
    input  logic [15:0]                     den,
    output logic                            done,
    output logic [dssl_pkg::QUOT_W-1:0]     quot
);

    logic [15:0]                 rem_reg;
    logic [15:0]                 den_reg;
    logic [dssl_pkg::QUOT_W-1:0] quot_reg;
    logic [3:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [16:0]                 shifted;
    logic [16:0]                 diff;
    logic                        fits;

    assign shifted = {rem_reg, 1'b0};
    assign diff = shifted - {1'b0, den_reg};
    assign fits = (shifted >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 4'(dssl_pkg::DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The partial remainder starts at num and shifts left each step, giving (num << QUOT_W) / den for num < den.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= diff[15:0];
                quot_reg <= {quot_reg[dssl_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[15:0];
                quot_reg <= {quot_reg[dssl_pkg::QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: rtl/dssl_datapath.sv
// Datapath: config registers, captured readings, guard limits, speed caps, LEDs, output beat.
module dssl_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic [103:0]         s_tdata,
    input  dssl_pkg::cmd_t       cmd,
    output dssl_pkg::stat_t      stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata
);

    // Configuration
    logic [15:0] stop_dist_reg;
    logic [15:0] brake_dist_reg;
    logic [15:0] batt_limit_reg;
    logic        batt_guard_reg;
    logic        front_guard_reg;
    logic        rear_guard_reg;

    // Captured readings
    logic [15:0]        pv_reg;
    logic [15:0]        cv_reg;
    logic [15:0]        fd_reg;
    logic               fc_reg;
    logic [15:0]        rd_reg;
    logic               rc_reg;
    logic signed [15:0] lcmd_reg;
    logic signed [15:0] rcmd_reg;

    logic signed [15:0] lcmd_in;
    logic signed [15:0] rcmd_in;

    // Guard results
    dssl_pkg::guard_t front_reg;
    dssl_pkg::guard_t rear_reg;
    dssl_pkg::guard_t front_eval;
    dssl_pkg::guard_t rear_eval;

    // Tick counter and LEDs
    logic [9:0] sub_reg;
    logic [4:0] kilo_reg;
    logic [7:0] led_reg [4];
    logic [7:0] led_next [4];

    logic                        div_done;
    logic [dssl_pkg::QUOT_W-1:0] quot;
    logic [15:0]                 div_num;
    logic [15:0]                 div_den;

    logic [1:0]         batt;
    logic signed [16:0] vl;
    logic signed [16:0] vr;
    logic signed [8:0]  right_word;
    logic signed [8:0]  left_word;
    logic signed [9:0]  left_neg;

    logic               m_tvalid_reg;
    logic [55:0]        m_tdata_reg;

    function automatic logic signed [15:0] sat_cmd(input logic signed [15:0] raw);
        logic signed [15:0] v;
        v = raw;
        if (raw > $signed(16'(dssl_pkg::ONE_Q14))) v = 16'(dssl_pkg::ONE_Q14);
        if (raw < -$signed(16'(dssl_pkg::ONE_Q14))) v = -$signed(16'(dssl_pkg::ONE_Q14));
        return v;
    endfunction

    function automatic dssl_pkg::guard_t guard_eval(
        input logic [15:0]                 d,
        input logic                        clear,
        input logic [15:0]                 lo,
        input logic [15:0]                 hi,
        input logic [dssl_pkg::QUOT_W-1:0] q
    );
        dssl_pkg::guard_t g;
        if (clear || d > hi) begin
            g.status = dssl_pkg::GUARD_FREE;
            g.lim = dssl_pkg::LIM_W'(dssl_pkg::ONE_Q14);
        end else if (d < lo) begin
            g.status = dssl_pkg::GUARD_STOP;
            g.lim = '0;
        end else if (hi == lo || d == hi) begin
            // empty band, or the top edge of the band: full speed
            g.status = dssl_pkg::GUARD_BRAKE;
            g.lim = dssl_pkg::LIM_W'(dssl_pkg::ONE_Q14);
        end else begin
            g.status = dssl_pkg::GUARD_BRAKE;
            g.lim = {1'b0, q};
        end
        return g;
    endfunction

    function automatic logic signed [16:0] limit_speed(
        input logic signed [15:0]         cmd_v,
        input logic                       cut,
        input logic                       fg,
        input logic                       rg,
        input logic [dssl_pkg::LIM_W-1:0] flim,
        input logic [dssl_pkg::LIM_W-1:0] rlim
    );
        logic signed [16:0] v;
        logic signed [16:0] fl;
        logic signed [16:0] rl;
        v = 17'(cmd_v);
        fl = $signed({2'b00, flim});
        rl = -$signed({2'b00, rlim});
        if (cut) v = '0;
        if (fg && cmd_v > 16'sd0 && fl < v) v = fl;
        if (rg && cmd_v < 16'sd0 && rl > v) v = rl;
        return v;
    endfunction

    // v * 200 / 16384, truncated toward zero
    function automatic logic signed [8:0] to_drive(input logic signed [16:0] v);
        logic signed [25:0] prod;
        logic signed [25:0] adj;
        prod = 26'(v) * $signed(26'(dssl_pkg::DRIVE_SCALE));
        adj = (prod < 26'sd0) ? prod + $signed(26'(dssl_pkg::ONE_Q14 - 1)) : prod;
        return adj[22:14];
    endfunction

    // Configuration writes; the port never stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_dist_reg <= 16'd51;
            brake_dist_reg <= 16'd128;
            batt_limit_reg <= 16'd1000;
            batt_guard_reg <= 1'b0;
            front_guard_reg <= 1'b0;
            rear_guard_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                dssl_pkg::CFG_STOP_DIST:   stop_dist_reg <= cfg_data;
                dssl_pkg::CFG_BRAKE_DIST:  brake_dist_reg <= cfg_data;
                dssl_pkg::CFG_BATT_LIMIT:  batt_limit_reg <= cfg_data;
                dssl_pkg::CFG_BATT_GUARD:  batt_guard_reg <= cfg_data[0];
                dssl_pkg::CFG_FRONT_GUARD: front_guard_reg <= cfg_data[0];
                dssl_pkg::CFG_REAR_GUARD:  rear_guard_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign lcmd_in = sat_cmd($signed(s_tdata[81:66]));
    assign rcmd_in = sat_cmd($signed(s_tdata[97:82]));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pv_reg <= s_tdata[15:0];
            cv_reg <= s_tdata[31:16];
            fd_reg <= s_tdata[47:32];
            fc_reg <= s_tdata[48];
            rd_reg <= s_tdata[64:49];
            rc_reg <= s_tdata[65];
            lcmd_reg <= lcmd_in;
            rcmd_reg <= rcmd_in;
        end
    end

    // Shared divider: (d - stop) << 14 / (start - stop)
    assign div_num = cmd.div_sel_rear ? rd_reg - stop_dist_reg : fd_reg - stop_dist_reg;
    assign div_den = brake_dist_reg - stop_dist_reg;

    dssl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (quot)
    );

    assign front_eval = guard_eval(fd_reg, fc_reg, stop_dist_reg, brake_dist_reg, quot);
    assign rear_eval = guard_eval(rd_reg, rc_reg, stop_dist_reg, brake_dist_reg, quot);

    always_ff @(posedge aclk) begin
        if (cmd.cap_front) front_reg <= front_eval;
        if (cmd.cap_rear) rear_reg <= rear_eval;
    end

    // Compute battery wins over the power battery
    always_comb begin
        if (cv_reg < batt_limit_reg) begin
            batt = dssl_pkg::BATT_COMPUTE;
        end else if (pv_reg < batt_limit_reg) begin
            batt = dssl_pkg::BATT_POWER;
        end else begin
            batt = dssl_pkg::BATT_OK;
        end
    end

    assign vl = limit_speed(lcmd_reg, batt_guard_reg && batt != dssl_pkg::BATT_OK,
                            front_guard_reg, rear_guard_reg, front_reg.lim, rear_reg.lim);
    assign vr = limit_speed(rcmd_reg, batt_guard_reg && batt != dssl_pkg::BATT_OK,
                            front_guard_reg, rear_guard_reg, front_reg.lim, rear_reg.lim);
    assign right_word = to_drive(vr);
    assign left_word = to_drive(vl);
    assign left_neg = -10'(left_word);

    // LED update for this tick
    always_comb begin
        for (int i = 0; i < 4; i++) led_next[i] = led_reg[i];
        if (batt == dssl_pkg::BATT_OK) begin
            led_next[0] = 8'd1;
            led_next[1] = 8'd2;
            led_next[2] = 8'd4;
            led_next[3] = 8'd8;
        end else if (sub_reg == '0) begin
            for (int i = 0; i < 4; i++) begin
                led_next[i] = kilo_reg[0] ? 8'd0 : dssl_pkg::BLINK_PATTERN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg <= '0;
            kilo_reg <= '0;
            for (int i = 0; i < 4; i++) led_reg[i] <= '0;
        end else if (cmd.emit) begin
            for (int i = 0; i < 4; i++) led_reg[i] <= led_next[i];
            if (kilo_reg == 5'(dssl_pkg::KILO_WRAP) && sub_reg == '0) begin
                kilo_reg <= '0;
            end else if (sub_reg == 10'(dssl_pkg::BLINK_PERIOD - 1)) begin
                sub_reg <= '0;
                kilo_reg <= kilo_reg + 5'd1;
            end else begin
                sub_reg <= sub_reg + 10'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {led_next[3], led_next[2], led_next[1], led_next[0],
                            rear_reg.status, front_reg.status, batt,
                            left_neg[8:0], right_word};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !m_tvalid_reg || m_tready;

`ifndef SYNTHESIS
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[8:0]) <= 9'sd200 && $signed(m_tdata[8:0]) >= -9'sd200
                      && $signed(m_tdata[17:9]) <= 9'sd200
                      && $signed(m_tdata[17:9]) >= -9'sd200))
        else $error("drive word out of range");
    a_batt_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:18] != 2'd3)
        else $error("bad battery status");
    a_tick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg < 10'(dssl_pkg::BLINK_PERIOD) && kilo_reg <= 5'(dssl_pkg::KILO_WRAP)
        && (kilo_reg != 5'(dssl_pkg::KILO_WRAP) || sub_reg == '0))
        else $error("tick counter out of range");
    a_led_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && batt == dssl_pkg::BATT_OK |=>
            m_tdata[55:24] == 32'h0804_0201)
        else $error("LEDs wrong with battery ok");
`endif

endmodule

// File: rtl/dssl_ctrl.sv
// Controller: sequences capture, the two divider runs and the output beat.
module dssl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dssl_pkg::stat_t   stat,
    output dssl_pkg::cmd_t    cmd
);

    dssl_pkg::state_t state_reg;
    dssl_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dssl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            dssl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = dssl_pkg::ST_FRONT_START;
                end
            end
            dssl_pkg::ST_FRONT_START: begin
                cmd.div_start = 1'b1;
                state_next = dssl_pkg::ST_FRONT_DIV;
            end
            dssl_pkg::ST_FRONT_DIV: begin
                if (stat.div_done) begin
                    cmd.cap_front = 1'b1;
                    state_next = dssl_pkg::ST_REAR_START;
                end
            end
            dssl_pkg::ST_REAR_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel_rear = 1'b1;
                state_next = dssl_pkg::ST_REAR_DIV;
            end
            dssl_pkg::ST_REAR_DIV: begin
                if (stat.div_done) begin
                    cmd.cap_rear = 1'b1;
                    state_next = dssl_pkg::ST_OUTPUT;
                end
            end
            dssl_pkg::ST_OUTPUT: begin
                // wait until the previous beat has left the output register
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = dssl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dssl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/drive_speed_safety_limiter_top.sv
// Top level of the drive speed safety limiter.
// Each input beat is one control tick: battery readings, front and rear distances with
// their clear flags, and left and right speed commands. The block answers with one output
// beat holding the limited drive words, the three guard states and four LED patterns.
// A tick is not accepted again until it is done: a capture state, then two runs of the
// shared 14-step restoring divider (front ratio, then rear), each a start state and a
// wait state that captures the ratio, and an output state that waits for the output
// register to be free. The result waits there while the next tick is accepted.
// Configuration writes are taken every cycle and must be made while the block is idle.
module drive_speed_safety_limiter_top (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    // input ticks
    input  logic         s_tvalid,
    output logic         s_tready,
    // power_voltage[15:0], compute_voltage[31:16], front_distance[47:32],
    // front_clear[48], rear_distance[64:49], rear_clear[65],
    // left_command[81:66], right_command[97:82], zero[103:98]
    input  logic [103:0] s_tdata,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // right_drive[8:0], left_drive[17:9], battery_status[19:18], front_status[21:20],
    // rear_status[23:22], led_first[31:24], led_second[39:32], led_third[47:40],
    // led_fourth[55:48]
    output logic [55:0]  m_tdata
);

    dssl_pkg::cmd_t  cmd;
    dssl_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    dssl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dssl_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: dv/drive_speed_safety_limiter_top_test.sv
// Self-checking testbench for the drive speed safety limiter top level.
`timescale 1ns / 100ps

module drive_speed_safety_limiter_top_test;

    localparam int SPEED_ONE = int'(dssl_pkg::ONE_Q14);
    localparam int DRIVE_FULL = int'(dssl_pkg::DRIVE_SCALE);
    localparam int unsigned TICK_WRAP = dssl_pkg::KILO_WRAP * dssl_pkg::BLINK_PERIOD;

    // One control tick as it travels on s_tdata, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] right_cmd;
        logic [15:0] left_cmd;
        logic        rear_clear;
        logic [15:0] rear_dist;
        logic        front_clear;
        logic [15:0] front_dist;
        logic [15:0] compute_v;
        logic [15:0] power_v;
    } tick_in_t;

    typedef struct packed {
        logic [7:0] led_fourth;
        logic [7:0] led_third;
        logic [7:0] led_second;
        logic [7:0] led_first;
        logic [1:0] rear_status;
        logic [1:0] front_status;
        logic [1:0] batt_status;
        logic [8:0] left_drive;
        logic [8:0] right_drive;
    } drive_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;

    drive_speed_safety_limiter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow of the block's registers and state, reset values
    logic [15:0] stop_q = 16'd51;
    logic [15:0] brake_q = 16'd128;
    logic [15:0] batt_limit_q = 16'd1000;
    logic        batt_guard_q = 1'b0;
    logic        front_guard_q = 1'b0;
    logic        rear_guard_q = 1'b0;
    int unsigned tick_q = 0;
    logic [7:0]  led_q [4] = '{8'd0, 8'd0, 8'd0, 8'd0};
    int unsigned ticks_taken = 0;

    drive_result_t pending_drives [$];
    drive_result_t got_beat;
    drive_result_t want_beat;
    int mismatch_count = 0;
    bit tx_gaps_on = 1'b0;
    bit rx_always_ready = 1'b0;
    int burst_left = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void guard_eval(input logic [15:0] d, input logic clr,
                                       output logic [1:0] st, output int lim);
        int unsigned off;
        int unsigned span;
        if (clr || d > brake_q) begin
            st = dssl_pkg::GUARD_FREE;
            lim = SPEED_ONE;
        end else if (d < stop_q) begin
            st = dssl_pkg::GUARD_STOP;
            lim = 0;
        end else if (brake_q == stop_q) begin
            st = dssl_pkg::GUARD_BRAKE;
            lim = SPEED_ONE;
        end else begin
            off = d - stop_q;
            span = brake_q - stop_q;
            st = dssl_pkg::GUARD_BRAKE;
            lim = int'((off * dssl_pkg::ONE_Q14) / span);
        end
    endfunction

    function automatic int clamp_cmd(input logic signed [15:0] raw);
        int v;
        v = raw;
        if (v > SPEED_ONE) v = SPEED_ONE;
        if (v < -SPEED_ONE) v = -SPEED_ONE;
        return v;
    endfunction

    function automatic int capped_speed(input int cmd, input logic [1:0] batt,
                                        input int flim, input int rlim);
        int v;
        v = cmd;
        if (batt_guard_q && batt != dssl_pkg::BATT_OK) v = 0;
        if (front_guard_q && cmd > 0 && flim < v) v = flim;
        if (rear_guard_q && cmd < 0 && -rlim > v) v = -rlim;
        return v;
    endfunction

    function automatic drive_result_t limit_tick(input tick_in_t t);
        logic [1:0] batt;
        logic [1:0] fs;
        logic [1:0] rs;
        int flim;
        int rlim;
        int vl;
        int vr;
        logic [7:0] blink;
        drive_result_t r;
        batt = dssl_pkg::BATT_OK;
        if (t.power_v < batt_limit_q) batt = dssl_pkg::BATT_POWER;
        if (t.compute_v < batt_limit_q) batt = dssl_pkg::BATT_COMPUTE;
        guard_eval(t.front_dist, t.front_clear, fs, flim);
        guard_eval(t.rear_dist, t.rear_clear, rs, rlim);
        vl = capped_speed(clamp_cmd(t.left_cmd), batt, flim, rlim);
        vr = capped_speed(clamp_cmd(t.right_cmd), batt, flim, rlim);

        if (batt != dssl_pkg::BATT_OK) begin
            if (tick_q % dssl_pkg::BLINK_PERIOD == 0) begin
                blink = ((tick_q / dssl_pkg::BLINK_PERIOD) % 2 == 0) ?
                        dssl_pkg::BLINK_PATTERN : 8'd0;
                for (int i = 0; i < 4; i++) led_q[i] = blink;
            end
        end else begin
            led_q = '{8'd1, 8'd2, 8'd4, 8'd8};
        end
        if (tick_q >= TICK_WRAP) tick_q = 0;
        else tick_q = tick_q + 1;
        ticks_taken++;

        // C-style division truncates toward zero; left word is negated
        r.right_drive = 9'((vr * DRIVE_FULL) / SPEED_ONE);
        r.left_drive = 9'(-((vl * DRIVE_FULL) / SPEED_ONE));
        r.batt_status = batt;
        r.front_status = fs;
        r.rear_status = rs;
        r.led_first = led_q[0];
        r.led_second = led_q[1];
        r.led_third = led_q[2];
        r.led_fourth = led_q[3];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_beat = m_tdata;
            if (pending_drives.size() == 0) begin
                if (mismatch_count < 10)
                    $display("result beat with nothing pending: %h", m_tdata);
                mismatch_count++;
            end else begin
                want_beat = pending_drives.pop_front();
                if (got_beat.right_drive !== want_beat.right_drive ||
                    got_beat.left_drive !== want_beat.left_drive ||
                    got_beat.batt_status !== want_beat.batt_status ||
                    got_beat.front_status !== want_beat.front_status ||
                    got_beat.rear_status !== want_beat.rear_status ||
                    got_beat.led_first !== want_beat.led_first ||
                    got_beat.led_second !== want_beat.led_second ||
                    got_beat.led_third !== want_beat.led_third ||
                    got_beat.led_fourth !== want_beat.led_fourth) begin
                    if (mismatch_count < 10) begin
                        $display("drive mismatch exp: R=%0d L=%0d batt=%0d f=%0d r=%0d led=%h",
                                 $signed(want_beat.right_drive),
                                 $signed(want_beat.left_drive), want_beat.batt_status,
                                 want_beat.front_status, want_beat.rear_status,
                                 want_beat[55:24]);
                        $display("               got: R=%0d L=%0d batt=%0d f=%0d r=%0d led=%h",
                                 $signed(got_beat.right_drive),
                                 $signed(got_beat.left_drive), got_beat.batt_status,
                                 got_beat.front_status, got_beat.rear_status,
                                 got_beat[55:24]);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver backpressure: segments of always-ready, random and heavy stall
    initial begin
        int seg;
        int mode;
        m_tready = 1'b0;
        forever begin
            seg = $urandom_range(4, 120);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                @(negedge aclk);
                if (rx_always_ready || mode == 0) m_tready = 1'b1;
                else if (mode == 1) m_tready = ($urandom_range(0, 1) == 1);
                else if (mode == 2) m_tready = ($urandom_range(0, 7) == 0);
                else m_tready = ($urandom_range(0, 3) != 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers; every task is entered and left just after a falling edge
    // ------------------------------------------------------------------
    task automatic wait_idle();
        while (pending_drives.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dssl_pkg::CFG_STOP_DIST:   stop_q = val;
            dssl_pkg::CFG_BRAKE_DIST:  brake_q = val;
            dssl_pkg::CFG_BATT_LIMIT:  batt_limit_q = val;
            dssl_pkg::CFG_BATT_GUARD:  batt_guard_q = val[0];
            dssl_pkg::CFG_FRONT_GUARD: front_guard_q = val[0];
            dssl_pkg::CFG_REAR_GUARD:  rear_guard_q = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] sd, input logic [15:0] bd,
                                  input logic [15:0] lim, input logic bg,
                                  input logic fg, input logic rg);
        wait_idle();
        write_reg(dssl_pkg::CFG_STOP_DIST, sd);
        write_reg(dssl_pkg::CFG_BRAKE_DIST, bd);
        write_reg(dssl_pkg::CFG_BATT_LIMIT, lim);
        write_reg(dssl_pkg::CFG_BATT_GUARD, {15'd0, bg});
        write_reg(dssl_pkg::CFG_FRONT_GUARD, {15'd0, fg});
        write_reg(dssl_pkg::CFG_REAR_GUARD, {15'd0, rg});
    endtask

    task automatic send_tick(input tick_in_t t);
        int gap;
        s_tvalid = 1'b1;
        s_tdata = t;
        do @(posedge aclk); while (!s_tready);
        pending_drives.push_back(limit_tick(t));
        @(negedge aclk);
        s_tvalid = 1'b0;
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 60);
                repeat (gap) @(negedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    function automatic tick_in_t make_tick(input logic [15:0] pv, cv, fd, input logic fc,
                                           input logic [15:0] rd, input logic rc,
                                           input logic [15:0] lc, rcm);
        tick_in_t t;
        t = '0;
        t.power_v = pv;
        t.compute_v = cv;
        t.front_dist = fd;
        t.front_clear = fc;
        t.rear_dist = rd;
        t.rear_clear = rc;
        t.left_cmd = lc;
        t.right_cmd = rcm;
        return t;
    endfunction

    // Distances cluster around the braking band edges
    function automatic logic [15:0] pick_dist();
        int unsigned lo_d;
        int unsigned hi_d;
        lo_d = (stop_q < brake_q) ? stop_q : brake_q;
        hi_d = (stop_q < brake_q) ? brake_q : stop_q;
        case ($urandom_range(0, 6))
            0: return 16'($urandom);
            1: return 16'(stop_q + $urandom_range(0, 4) - 2);
            2: return 16'(brake_q + $urandom_range(0, 4) - 2);
            3, 4: return 16'($urandom_range(lo_d, hi_d));
            5: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_volt();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'(batt_limit_q + $urandom_range(0, 2) - 1);
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom_range(batt_limit_q, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] pick_cmd();
        case ($urandom_range(0, 9))
            8: return 16'($urandom);
            9: begin
                case ($urandom_range(0, 4))
                    0: return 16'h4000;
                    1: return 16'hC000;
                    2: return 16'h0000;
                    3: return 16'h8000;
                    default: return 16'h7FFF;
                endcase
            end
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic tick_in_t rand_tick();
        return make_tick(pick_volt(), pick_volt(), pick_dist(), $urandom_range(0, 3) == 0,
                         pick_dist(), $urandom_range(0, 3) == 0, pick_cmd(), pick_cmd());
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings, guards off: statuses follow readings, speeds pass through
    task automatic test_reset_defaults();
        tx_gaps_on = 1'b0;
        // power low on the very first tick blinks the LEDs on
        send_tick(make_tick(16'd0, 16'd5000, 16'h0010, 1'b0, 16'hFFFF, 1'b0,
                            16'h2000, 16'hE000));
        send_tick(make_tick(16'd5000, 16'd0, 16'hFFFF, 1'b0, 16'h0060, 1'b0,
                            16'h4000, 16'hC000));
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0040, 1'b0, 16'h0020, 1'b0,
                            16'h1234, 16'hF000));
    endtask

    task automatic test_directed_guards();
        apply_settings(16'h0300, 16'h0800, 16'd1000, 1'b1, 1'b1, 1'b1);
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0, 1'b1, 16'h0, 1'b1, 16'h4000, 16'hC000));
        // out of range commands saturate
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0, 1'b1, 16'h0, 1'b1, 16'h4001, 16'h8000));
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0, 1'b1, 16'h0, 1'b1, 16'h7FFF, 16'hBFFF));
        // front braking band caps forward speed only
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0500, 1'b0, 16'h0, 1'b1,
                            16'h4000, 16'h2000));
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0100, 1'b0, 16'h0, 1'b1,
                            16'h4000, 16'(-8000)));
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0300, 1'b0, 16'h0, 1'b1,
                            16'd100, 16'h4000));
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0800, 1'b0, 16'h0, 1'b1,
                            16'h4000, 16'h4000));
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0000, 1'b0, 16'hFFFF, 1'b0,
                            16'h4000, 16'hC000));
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0000, 1'b1, 16'hFFFF, 1'b1,
                            16'h4000, 16'hC000));
        // rear band caps reverse speed only
        send_tick(make_tick(16'd5000, 16'd5000, 16'hFFFF, 1'b1, 16'h0600, 1'b0,
                            16'hC000, 16'(-4000)));
        send_tick(make_tick(16'd5000, 16'd5000, 16'hFFFF, 1'b1, 16'h0200, 1'b0,
                            16'hC000, 16'h4000));
        // battery thresholds; compute battery wins when both are empty
        send_tick(make_tick(16'd999, 16'd5000, 16'h0, 1'b1, 16'h0, 1'b1, 16'h4000, 16'hC000));
        send_tick(make_tick(16'd1000, 16'd999, 16'h0, 1'b1, 16'h0, 1'b1, 16'h4000, 16'h4000));
        send_tick(make_tick(16'd0, 16'd0, 16'h0, 1'b1, 16'h0, 1'b1, 16'hC000, 16'hC000));
        send_tick(make_tick(16'd1000, 16'd1000, 16'h0, 1'b1, 16'h0, 1'b1, 16'hFFFF, 16'h0001));

        // brake start equal to stop distance
        apply_settings(16'h0400, 16'h0400, 16'd1000, 1'b1, 1'b1, 1'b1);
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0400, 1'b0, 16'h0400, 1'b0,
                            16'h4000, 16'hC000));
        send_tick(make_tick(16'd5000, 16'd5000, 16'h03FF, 1'b0, 16'h0401, 1'b0,
                            16'h4000, 16'hC000));

        // brake start below stop distance
        apply_settings(16'h0800, 16'h0400, 16'd1000, 1'b1, 1'b1, 1'b1);
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0600, 1'b0, 16'h0401, 1'b0,
                            16'h4000, 16'hC000));
        send_tick(make_tick(16'd5000, 16'd5000, 16'h0400, 1'b0, 16'h0800, 1'b0,
                            16'hC000, 16'h4000));
    endtask

    task automatic test_random_settings();
        logic [15:0] sd;
        logic [15:0] bd;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_settings(16'd51, 16'd128, 16'd1000, 1'b1, 1'b1, 1'b1);
                1: apply_settings(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1);
                2: apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
                3: apply_settings(16'h1000, 16'h1000, 16'd1000, 1'b0, 1'b1, 1'b0);
                4: apply_settings(16'h0000, 16'h0000, 16'($urandom_range(0, 4000)),
                                  1'b0, 1'b0, 1'b1);
                default: begin
                    sd = 16'($urandom_range(0, 8000));
                    bd = 16'(sd + $urandom_range(0, 8000));
                    apply_settings(sd, bd, 16'($urandom_range(0, 4000)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                end
            endcase
            // every third phase sends back to back, the other phases are paced
            tx_gaps_on = (phase % 3 != 2);
            repeat (76) send_tick(rand_tick());
        end
        tx_gaps_on = 1'b0;
    endtask

    // Stretches of empty and good batteries: LED patterns are held between blink ticks
    task automatic test_led_hold();
        tick_in_t t;
        apply_settings(16'd51, 16'd128, 16'd1000, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        tx_gaps_on = 1'b0;
        rx_always_ready = 1'b1;
        while (ticks_taken < 650) begin
            t = rand_tick();
            if ((ticks_taken / 5) % 2 == 0) begin
                if ($urandom_range(0, 1) == 1) t.power_v = 16'd0;
                else t.compute_v = 16'd0;
            end
            send_tick(t);
        end
        rx_always_ready = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = dssl_pkg::CFG_STOP_DIST;
        cfg_data = 16'd0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_directed_guards();
        test_random_settings();
        test_led_hold();

        wait_idle();
        repeat (50) @(negedge aclk);
        if (mismatch_count == 0 && pending_drives.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
